// File: design/lpc_pkg.sv
// types, constants and helper functions shared by the lidar point converter
package lpc_pkg;

  localparam int CW = 34;
  localparam int ZW = 32;
  localparam int RW = 27;
  localparam int PW = 51;

  localparam logic [1:0] REG_MIN_EL   = 2'd0;
  localparam logic [1:0] REG_MAX_EL   = 2'd1;
  localparam logic [1:0] REG_CHANNELS = 2'd2;

  localparam logic signed [14:0] MIN_EL_RST   = -15'sd1500;
  localparam logic signed [14:0] MAX_EL_RST   = 15'sd1500;
  localparam logic [7:0]         CHANNELS_RST = 8'd16;

  localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;

  typedef struct packed {
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [ZW-1:0] az;
    logic                 aneg;
    logic signed [CW-1:0] ex;
    logic signed [CW-1:0] ey;
    logic signed [ZW-1:0] ez;
    logic                 eneg;
    logic [17:0]          rng;
    logic [15:0]          inten;
    logic [RW-1:0]        rem;
    logic [16:0]          dvs;
    logic [7:0]           quo;
    logic                 ovf;
    logic                 ring_en;
  } lpc_item_t;

  typedef struct packed {
    logic signed [16:0] ang;
    logic               neg;
  } lpc_fold_t;

  function automatic logic signed [ZW-1:0] lpc_atan(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0:  v = 32'sd294912000;
      1:  v = 32'sd174096719;
      2:  v = 32'sd91987925;
      3:  v = 32'sd46694507;
      4:  v = 32'sd23437865;
      5:  v = 32'sd11730458;
      6:  v = 32'sd5866610;
      7:  v = 32'sd2933484;
      8:  v = 32'sd1466765;
      9:  v = 32'sd733385;
      10: v = 32'sd366693;
      11: v = 32'sd183347;
      12: v = 32'sd91674;
      13: v = 32'sd45837;
      14: v = 32'sd22918;
      15: v = 32'sd11459;
      16: v = 32'sd5730;
      17: v = 32'sd2865;
      18: v = 32'sd1432;
      19: v = 32'sd716;
      20: v = 32'sd358;
      21: v = 32'sd179;
      22: v = 32'sd90;
      23: v = 32'sd45;
      default: v = '0;
    endcase
    return v;
  endfunction

  // fold into [-90, +90] degrees, flagging a sign flip of sin and cos
  function automatic lpc_fold_t lpc_fold(input logic signed [16:0] a);
    lpc_fold_t f;
    f.ang = a;
    f.neg = 1'b0;
    if (a > 17'sd9000) begin
      f.ang = a - 17'sd18000;
      f.neg = 1'b1;
    end else if (a < -17'sd9000) begin
      f.ang = a + 17'sd18000;
      f.neg = 1'b1;
    end
    return f;
  endfunction

  function automatic logic signed [15:0] lpc_sat16(input logic signed [CW-1:0] t);
    logic signed [15:0] r;
    if (t > 34'sd32767) begin
      r = 16'sd32767;
    end else if (t < -34'sd32768) begin
      r = -16'sd32768;
    end else begin
      r = 16'(t);
    end
    return r;
  endfunction

  // Q2.30 to Q1.15, half away from zero, with optional negation
  function automatic logic signed [15:0] lpc_trig(input logic signed [CW-1:0] v,
                                                  input logic neg);
    logic signed [CW-1:0] t;
    logic signed [15:0]   s;
    if (!v[CW-1]) begin
      t = (v + 34'sd16384) >>> 15;
    end else begin
      t = -((-v + 34'sd16384) >>> 15);
    end
    s = lpc_sat16(t);
    if (neg) begin
      s = lpc_sat16(-CW'(s));
    end
    return s;
  endfunction

  function automatic logic signed [18:0] lpc_pos(input logic signed [PW-1:0] v,
                                                 input int n, input logic negate);
    logic signed [PW-1:0] half;
    logic signed [PW-1:0] t;
    logic signed [18:0]   r;
    half = 51'sd1 <<< (n - 1);
    if (!v[PW-1]) begin
      t = (v + half) >>> n;
    end else begin
      t = -((-v + half) >>> n);
    end
    if (negate) begin
      t = -t;
    end
    if (t > 51'sd262143) begin
      r = 19'sd262143;
    end else if (t < -51'sd262144) begin
      r = -19'sd262144;
    end else begin
      r = 19'(t);
    end
    return r;
  endfunction

endpackage

// File: design/lpc_in_if.sv
// return channel: one lidar return per transfer
interface lpc_in_if;
  logic               valid;
  logic               ready;
  logic [15:0]        azimuth;
  logic signed [14:0] elevation;
  logic [17:0]        range_mm;
  logic [15:0]        intensity_in;

  modport source (output valid, azimuth, elevation, range_mm, intensity_in, input ready);
  modport sink (input valid, azimuth, elevation, range_mm, intensity_in, output ready);
endinterface

// File: design/lpc_out_if.sv
// point channel: one cartesian point per transfer
interface lpc_out_if;
  logic               valid;
  logic               ready;
  logic signed [18:0] pos_x;
  logic signed [18:0] pos_y;
  logic signed [18:0] pos_z;
  logic [15:0]        intensity_out;
  logic [6:0]         ring_index;

  modport source (output valid, pos_x, pos_y, pos_z, intensity_out, ring_index,
                  input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, intensity_out, ring_index,
                output ready);
endinterface

// File: design/lpc_cfg_if.sv
// register write channel
interface lpc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [14:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: design/lpc_prep.sv
// input stage: angle reduction, cordic seeds and ring dividend
module lpc_prep import lpc_pkg::*; #(
  parameter int RANGE_BITS = 18
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  input  logic [15:0]        azimuth,
  input  logic signed [14:0] elevation,
  input  logic [17:0]        range_mm,
  input  logic [15:0]        intensity_in,
  input  logic signed [14:0] min_el,
  input  logic signed [14:0] max_el,
  input  logic [7:0]         channels,
  output logic               up_ready,
  output logic               dn_valid,
  output lpc_item_t          dn_data,
  input  logic               dn_ready
);

  localparam int RB = (RANGE_BITS < 18) ? RANGE_BITS : 18;

  logic [16:0]        az_u;
  logic signed [16:0] az_s;
  lpc_fold_t          az_f;
  lpc_fold_t          el_f;
  logic [7:0]         top;
  logic signed [16:0] diff;
  logic signed [16:0] den;
  logic signed [25:0] num;
  logic signed [RW-1:0] dividend;
  lpc_item_t          item;

  always_comb begin
    az_u = {1'b0, azimuth};
    if (az_u >= 17'd36000) begin
      az_u = az_u - 17'd36000;
    end
    az_s = $signed(az_u);
    if (az_s > 17'sd18000) begin
      az_s = az_s - 17'sd36000;
    end
    az_f = lpc_fold(az_s);
    el_f = lpc_fold(17'(elevation));

    top      = channels - 8'd1;
    diff     = 17'(elevation) - 17'(min_el);
    den      = 17'(max_el) - 17'(min_el);
    num      = diff * $signed({1'b0, top});
    dividend = (RW'(num) <<< 1) + RW'(den);

    item.ax      = CORDIC_X0;
    item.ay      = '0;
    item.az      = ZW'(az_f.ang) <<< 16;
    item.aneg    = az_f.neg;
    item.ex      = CORDIC_X0;
    item.ey      = '0;
    item.ez      = ZW'(el_f.ang) <<< 16;
    item.eneg    = el_f.neg;
    item.rng     = 18'(range_mm[RB-1:0]);
    item.inten   = intensity_in;
    item.rem     = $unsigned(dividend);
    item.dvs     = {den[15:0], 1'b0};
    item.quo     = '0;
    item.ovf     = 1'b0;
    item.ring_en = (channels >= 8'd2) && (max_el > min_el) && (num > 26'sd0);
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= item;
    end
  end

endmodule

// File: design/lpc_cell.sv
// one cordic micro-rotation for both angles, plus one ring quotient bit in cells 0 to 7
module lpc_cell import lpc_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      up_valid,
  input  lpc_item_t up_data,
  output logic      up_ready,
  output logic      dn_valid,
  output lpc_item_t dn_data,
  input  logic      dn_ready
);

  localparam logic signed [ZW-1:0] ATAN = lpc_atan(IDX);

  lpc_item_t            item;
  logic signed [CW-1:0] axs, ays, exs, eys;

  always_comb begin
    item = up_data;
    axs  = up_data.ax >>> IDX;
    ays  = up_data.ay >>> IDX;
    exs  = up_data.ex >>> IDX;
    eys  = up_data.ey >>> IDX;
    if (!up_data.az[ZW-1]) begin
      item.ax = up_data.ax - ays;
      item.ay = up_data.ay + axs;
      item.az = up_data.az - ATAN;
    end else begin
      item.ax = up_data.ax + ays;
      item.ay = up_data.ay - axs;
      item.az = up_data.az + ATAN;
    end
    if (!up_data.ez[ZW-1]) begin
      item.ex = up_data.ex - eys;
      item.ey = up_data.ey + exs;
      item.ez = up_data.ez - ATAN;
    end else begin
      item.ex = up_data.ex + eys;
      item.ey = up_data.ey - exs;
      item.ez = up_data.ez + ATAN;
    end
  end

  lpc_item_t step;

  generate
    if (IDX < 8) begin : g_div
      localparam int B = 7 - IDX;
      logic [RW-1:0] sub;
      always_comb begin
        step = item;
        sub  = RW'(up_data.dvs) << B;
        if (up_data.rem >= sub) begin
          step.rem    = up_data.rem - sub;
          step.quo[B] = 1'b1;
        end
        if (IDX == 0) begin
          step.ovf = up_data.rem >= (RW'(up_data.dvs) << 8);
        end
      end
    end else begin : g_rot
      always_comb begin
        step = item;
      end
    end
  endgenerate

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= step;
    end
  end

endmodule

// File: design/lpc_post.sv
// back end: trig rounding, ring saturation, products and output register
module lpc_post import lpc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      up_valid,
  input  lpc_item_t up_data,
  output logic      up_ready,
  input  logic [7:0] channels,
  lpc_out_if.source points
);

  logic [4:1] v;
  logic [5:1] rdy;

  // stage 1
  logic signed [15:0] ca, sa, ce, se;
  logic [17:0]        r1;
  logic [15:0]        i1;
  logic [6:0]         g1;
  // stage 2
  logic signed [31:0] cc, cs;
  logic signed [34:0] zp;
  logic [17:0]        r2;
  logic [15:0]        i2;
  logic [6:0]         g2;
  // stage 3
  logic signed [PW-1:0] px, py;
  logic signed [18:0]   pz;
  logic [15:0]          i3;
  logic [6:0]           g3;

  logic [7:0] qv;
  logic [7:0] top;
  logic [6:0] lim;
  logic [6:0] ring_next;

  always_comb begin
    qv  = up_data.ovf ? 8'd255 : up_data.quo;
    top = channels - 8'd1;
    lim = (top > 8'd127) ? 7'd127 : top[6:0];
    if (!up_data.ring_en) begin
      ring_next = '0;
    end else if (qv > {1'b0, lim}) begin
      ring_next = lim;
    end else begin
      ring_next = qv[6:0];
    end
  end

  assign rdy[5] = points.ready;
  assign rdy[4] = !v[4] || rdy[5];
  assign rdy[3] = !v[3] || rdy[4];
  assign rdy[2] = !v[2] || rdy[3];
  assign rdy[1] = !v[1] || rdy[2];
  assign up_ready = rdy[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[1]) v[1] <= up_valid;
      if (rdy[2]) v[2] <= v[1];
      if (rdy[3]) v[3] <= v[2];
      if (rdy[4]) v[4] <= v[3];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1] && up_valid) begin
      ca <= lpc_trig(up_data.ax, up_data.aneg);
      sa <= lpc_trig(up_data.ay, up_data.aneg);
      ce <= lpc_trig(up_data.ex, up_data.eneg);
      se <= lpc_trig(up_data.ey, up_data.eneg);
      r1 <= up_data.rng;
      i1 <= up_data.inten;
      g1 <= ring_next;
    end
    if (rdy[2] && v[1]) begin
      cc <= ce * ca;
      cs <= ce * sa;
      zp <= $signed({1'b0, r1}) * se;
      r2 <= r1;
      i2 <= i1;
      g2 <= g1;
    end
    if (rdy[3] && v[2]) begin
      px <= PW'($signed({1'b0, r2}) * cc);
      py <= PW'($signed({1'b0, r2}) * cs);
      pz <= lpc_pos(PW'(zp), 15, 1'b0);
      i3 <= i2;
      g3 <= g2;
    end
    if (rdy[4] && v[3]) begin
      points.pos_x         <= lpc_pos(px, 30, 1'b0);
      points.pos_y         <= lpc_pos(py, 30, 1'b1);
      points.pos_z         <= pz;
      points.intensity_out <= i3;
      points.ring_index    <= g3;
    end
  end

  assign points.valid = v[4];

endmodule

// File: design/lidar_polar_to_cartesian.sv
// top level: lidar return to forward-left-up point converter
//
//   channel  dir  transfer carries
//   returns  in   azimuth, elevation, range_mm, intensity_in
//   points   out  pos_x, pos_y, pos_z, intensity_out, ring_index
//   cfg      in   index, data (min_elevation, max_elevation, channel_count)
//
// one return accepted per cycle while intake is not blocked; a return passes
// the input stage, the row of cordic cells (one micro-rotation each) and the
// back-end stages. every stage has its own valid and is refilled as soon as
// it empties, so a stalled point only blocks intake once all stages hold data.
// synchronous reset clears the pipeline and loads the register defaults;
// cfg is always ready.
module lidar_polar_to_cartesian import lpc_pkg::*; #(
  parameter int RANGE_BITS  = 18,
  parameter int TRIG_STAGES = 16
) (
  input  logic       clk,
  input  logic       rst,
  lpc_in_if.sink     returns,
  lpc_out_if.source  points,
  lpc_cfg_if.sink    cfg
);

  logic signed [14:0] min_el;
  logic signed [14:0] max_el;
  logic [7:0]         channels;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_el   <= MIN_EL_RST;
      max_el   <= MAX_EL_RST;
      channels <= CHANNELS_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_MIN_EL:   min_el   <= $signed(cfg.data);
        REG_MAX_EL:   max_el   <= $signed(cfg.data);
        REG_CHANNELS: channels <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  logic [TRIG_STAGES:0] sv;
  logic [TRIG_STAGES:0] sr;
  lpc_item_t            sd [TRIG_STAGES+1];

  lpc_prep #(.RANGE_BITS(RANGE_BITS)) u_prep (
    .clk          (clk),
    .rst          (rst),
    .up_valid     (returns.valid),
    .azimuth      (returns.azimuth),
    .elevation    (returns.elevation),
    .range_mm     (returns.range_mm),
    .intensity_in (returns.intensity_in),
    .min_el       (min_el),
    .max_el       (max_el),
    .channels     (channels),
    .up_ready     (returns.ready),
    .dn_valid     (sv[0]),
    .dn_data      (sd[0]),
    .dn_ready     (sr[0])
  );

  generate
    for (genvar k = 0; k < TRIG_STAGES; k++) begin : g_cell
      lpc_cell #(.IDX(k)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .up_valid (sv[k]),
        .up_data  (sd[k]),
        .up_ready (sr[k]),
        .dn_valid (sv[k+1]),
        .dn_data  (sd[k+1]),
        .dn_ready (sr[k+1])
      );
    end
  endgenerate

  lpc_post u_post (
    .clk      (clk),
    .rst      (rst),
    .up_valid (sv[TRIG_STAGES]),
    .up_data  (sd[TRIG_STAGES]),
    .up_ready (sr[TRIG_STAGES]),
    .channels (channels),
    .points   (points)
  );

endmodule

// File: design/lpc_checker.sv
// port-level checks for the lidar point converter, bound to the top level
module lpc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [15:0] out_intensity,
  input logic       cfg_ready
);

  // intake only stops when a point is held back at the output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("intake stalled without output backpressure");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("point dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(out_intensity))
    else $error("stalled point changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("point presented after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("register port not ready");

endmodule

bind lidar_polar_to_cartesian lpc_checker u_lpc_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (returns.ready),
  .out_valid     (points.valid),
  .out_ready     (points.ready),
  .out_intensity (points.intensity_out),
  .cfg_ready     (cfg.ready)
);

// File: dv/tb_top.sv
// testbench for the lidar return to cartesian point converter
`timescale 1ns / 1ps

module tb_top;
  import lpc_pkg::*;

  localparam int RANGE_BITS  = 18;
  localparam int TRIG_STAGES = 16;
  localparam int LATENCY     = TRIG_STAGES + 5;
  localparam logic [1:0] REG_SPARE = 2'd3;

  localparam longint ARCTAN [24] = '{
    294912000, 174096719, 91987925, 46694507, 23437865, 11730458,
    5866610, 2933484, 1466765, 733385, 366693, 183347,
    91674, 45837, 22918, 11459, 5730, 2865,
    1432, 716, 358, 179, 90, 45
  };

  typedef struct {
    logic [15:0]        az;
    logic signed [14:0] el;
    logic [17:0]        rng;
    logic [15:0]        inten;
  } lidar_ret_t;

  typedef struct {
    logic signed [18:0] x;
    logic signed [18:0] y;
    logic signed [18:0] z;
    logic [15:0]        inten;
    logic [6:0]         ring;
  } point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lpc_in_if  ret_if ();
  lpc_out_if pt_if ();
  lpc_cfg_if cfg_if ();

  lidar_polar_to_cartesian #(
    .RANGE_BITS (RANGE_BITS),
    .TRIG_STAGES(TRIG_STAGES)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .returns(ret_if.sink),
    .points (pt_if.source),
    .cfg    (cfg_if.sink)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lidar_ret_t  pending_rets[$];
  point_t      expected_pts[$];
  int          n_errors = 0;
  int          n_points = 0;
  int          n_returns = 0;
  int          n_cfg = 0;
  bit          idle_en = 1'b1;
  logic        hold_off = 1'b0;
  int          src_gap = 0;
  int          snk_gap = 0;

  int          cur_min_el = -1500;
  int          cur_max_el = 1500;
  int          cur_channels = 16;

  function automatic longint round_away(longint v, int n);
    longint half;
    half = longint'(1) <<< (n - 1);
    if (v >= 0) return (v + half) >>> n;
    return -((-v + half) >>> n);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void cordic_sin_cos(input int centi, output longint s, output longint c);
    int     a;
    bit     neg;
    longint x, y, z, xs, ys;
    a = centi % 36000;
    neg = 1'b0;
    if (a < 0) a += 36000;
    if (a > 18000) a -= 36000;
    if (a > 9000) begin
      a -= 18000;
      neg = 1'b1;
    end else if (a < -9000) begin
      a += 18000;
      neg = 1'b1;
    end
    x = 652032874;
    y = 0;
    z = longint'(a) * 65536;
    for (int i = 0; i < TRIG_STAGES && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys;
        y += xs;
        z -= ARCTAN[i];
      end else begin
        x += ys;
        y -= xs;
        z += ARCTAN[i];
      end
    end
    x = clip(round_away(x, 15), -32768, 32767);
    y = clip(round_away(y, 15), -32768, 32767);
    if (neg) begin
      x = clip(-x, -32768, 32767);
      y = clip(-y, -32768, 32767);
    end
    s = y;
    c = x;
  endfunction

  function automatic point_t convert_return(lidar_ret_t rt);
    point_t p;
    longint sa, ca, se, ce, r, top, den, num, q;
    cordic_sin_cos(int'(rt.az), sa, ca);
    cordic_sin_cos(int'(rt.el), se, ce);
    r = longint'(rt.rng) & ((longint'(1) << RANGE_BITS) - 1);
    p.x = 19'(clip(round_away(r * ce * ca, 30), -262144, 262143));
    p.y = 19'(clip(-round_away(r * ce * sa, 30), -262144, 262143));
    p.z = 19'(clip(round_away(r * se, 15), -262144, 262143));
    p.inten = rt.inten;
    q = 0;
    if (cur_channels >= 2 && cur_max_el > cur_min_el) begin
      top = cur_channels - 1;
      den = cur_max_el - cur_min_el;
      num = (longint'(rt.el) - cur_min_el) * top;
      if (top > 127) top = 127;
      if (num > 0) q = (2 * num + den) / (2 * den);
      if (q > top) q = top;
    end
    p.ring = 7'(q);
    return p;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    n_errors++;
    $display("mismatch on point %0d: %s got %0d expected %0d", n_points, what, got, want);
  endtask

  // return driver
  always @(posedge clk) begin
    if (rst) begin
      ret_if.valid <= 1'b0;
      ret_if.azimuth <= '0;
      ret_if.elevation <= '0;
      ret_if.range_mm <= '0;
      ret_if.intensity_in <= '0;
    end else begin
      if (ret_if.valid && ret_if.ready) begin
        expected_pts.push_back(convert_return(pending_rets[0]));
        void'(pending_rets.pop_front());
        n_returns++;
      end
      if (!ret_if.valid || ret_if.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          ret_if.valid <= 1'b0;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
          src_gap = $urandom_range(1, 4) - 1;
          ret_if.valid <= 1'b0;
        end else if (pending_rets.size() > 0) begin
          ret_if.valid <= 1'b1;
          ret_if.azimuth <= pending_rets[0].az;
          ret_if.elevation <= pending_rets[0].el;
          ret_if.range_mm <= pending_rets[0].rng;
          ret_if.intensity_in <= pending_rets[0].inten;
        end else begin
          ret_if.valid <= 1'b0;
        end
      end
    end
  end

  // point monitor
  always @(posedge clk) begin
    point_t w;
    if (rst) begin
      pt_if.ready <= 1'b0;
    end else begin
      if (pt_if.valid && pt_if.ready) begin
        if (expected_pts.size() == 0) begin
          report_mismatch("unexpected point transfer", 1, 0);
        end else begin
          w = expected_pts.pop_front();
          if (pt_if.pos_x !== w.x) report_mismatch("pos_x", pt_if.pos_x, w.x);
          if (pt_if.pos_y !== w.y) report_mismatch("pos_y", pt_if.pos_y, w.y);
          if (pt_if.pos_z !== w.z) report_mismatch("pos_z", pt_if.pos_z, w.z);
          if (pt_if.intensity_out !== w.inten)
            report_mismatch("intensity_out", pt_if.intensity_out, w.inten);
          if (pt_if.ring_index !== w.ring)
            report_mismatch("ring_index", pt_if.ring_index, w.ring);
        end
        n_points++;
      end
      if (hold_off) begin
        pt_if.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        pt_if.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        snk_gap = $urandom_range(1, 4) - 1;
        pt_if.ready <= 1'b0;
      end else begin
        pt_if.ready <= 1'b1;
      end
    end
  end

  // long back-pressure stretch, counted here
  bit stall_go = 1'b0;
  initial begin
    wait (stall_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (200) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    #2_000_000;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

  task automatic write_reg(logic [1:0] idx, int val);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= 15'(val);
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    n_cfg++;
    unique case (idx)
      REG_MIN_EL:   cur_min_el = int'($signed(15'(val)));
      REG_MAX_EL:   cur_max_el = int'($signed(15'(val)));
      REG_CHANNELS: cur_channels = val & 8'hFF;
      default: ;
    endcase
  endtask

  task automatic set_geometry(int lo, int hi, int ch);
    write_reg(REG_MIN_EL, lo);
    write_reg(REG_MAX_EL, hi);
    write_reg(REG_CHANNELS, ch);
  endtask

  task automatic add_return(int az, int el, int rng, int inten);
    lidar_ret_t rt;
    rt.az = 16'(az);
    rt.el = 15'(el);
    rt.rng = 18'(rng);
    rt.inten = 16'(inten);
    pending_rets.push_back(rt);
  endtask

  task automatic add_random(int n);
    int az, el, rng;
    repeat (n) begin
      az = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 35999);
      if ($urandom_range(0, 9) == 0) el = $urandom_range(0, 32767) - 16384;
      else el = $urandom_range(0, 18000) - 9000;
      rng = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 262143);
      add_return(az, el, rng, $urandom_range(0, 65535));
    end
  endtask

  task automatic drain();
    while (pending_rets.size() > 0 || ret_if.valid || expected_pts.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed, reset geometry
    add_return(0, 0, 262143, 0);
    add_return(35999, 0, 262143, 65535);
    add_return(9000, 0, 100000, 1);
    add_return(18000, 0, 100000, 2);
    add_return(27000, 0, 100000, 3);
    add_return(65535, 0, 100000, 4);
    add_return(36000, 4500, 100000, 5);
    add_return(1234, 9000, 262143, 6);
    add_return(1234, -9000, 262143, 7);
    add_return(500, 16383, 200000, 8);
    add_return(500, -16384, 200000, 9);
    add_return(4500, -1500, 0, 10);
    add_return(4500, 1500, 1000, 11);
    add_return(4500, -1600, 1000, 12);
    add_return(4500, 1600, 1000, 13);
    add_return(4500, -1400, 1000, 14);
    add_return(31500, 100, 262143, 15);
    drain();

    set_geometry(-9000, 9000, 128);
    stall_go = 1'b1;
    add_random(110);
    drain();

    set_geometry(9000, -9000, 2);
    add_random(80);
    drain();

    set_geometry(-2500, 1500, 255);
    write_reg(REG_SPARE, 15'h7FFF);
    add_random(110);
    drain();

    set_geometry(0, 1, 0);
    add_random(60);
    drain();

    set_geometry(-3000, 1000, 64);
    add_random(60);
    drain();

    idle_en = 1'b0;
    set_geometry(-1500, 1500, 16);
    add_random(130);
    drain();

    $display("converted %0d returns to %0d points over %0d register writes",
             n_returns, n_points, n_cfg);
    $display("geometry ranged over full span, inverted, zero, 2 and 255 channels");
    if (n_errors == 0 && expected_pts.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d errors, %0d points outstanding", n_errors, expected_pts.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
